// File: hdl/rqdo_pkg.sv
// ----------------------------------------------------------------------------
// rqdo_pkg: shared types for the drop-oldest ring queue
// Beat layouts, opcodes and the command and search structs used by the
// sequencer and the row of entry cells.
// ----------------------------------------------------------------------------
package rqdo_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int TAG_W     = 16;
    localparam int HANDLE_W  = 16;
    localparam int LVL_W     = 7;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2,
        OP_DEREF   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 opcode;
        logic [TAG_W-1:0]    in_tag;
        logic [HANDLE_W-1:0] in_handle;
    } in_beat_t;

    typedef struct packed {
        logic                ok;
        logic [TAG_W-1:0]    out_tag;
        logic [HANDLE_W-1:0] out_handle;
        logic                dropped;
        logic [LVL_W-1:0]    fill_level;
        logic [LVL_W-1:0]    peak_level;
    } out_beat_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                shift;
        logic                write;
        logic                clear;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } cell_cmd_t;

    // First live entry at or behind a cell, handed toward the head.
    typedef struct packed {
        logic                hit;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } cand_t;

endpackage

// File: hdl/rqdo_cell.sv
// ----------------------------------------------------------------------------
// rqdo_cell: one entry of the queue
// Holds one tag and handle, takes its neighbor's entry on a pop, loads a new
// entry at the tail, clears itself on a matching dereference, and passes the
// first-live-entry search one step toward the head each cycle.
// ----------------------------------------------------------------------------
module rqdo_cell
    import rqdo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cell_cmd_t                    cmd,
    input  logic [$clog2(DEPTH+1)-1:0]   fill,
    input  logic [TAG_W-1:0]             nb_tag,
    input  logic [HANDLE_W-1:0]          nb_handle,
    input  cand_t                        nb_cand,
    output logic [TAG_W-1:0]             tag,
    output logic [HANDLE_W-1:0]          handle,
    output cand_t                        cand
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [TAG_W-1:0]    tag_reg;
    logic [HANDLE_W-1:0] handle_reg;
    cand_t               cand_reg;
    cand_t               cand_next;
    logic                in_fill;
    logic                live;

    assign in_fill = fill > CNT_W'(IDX);
    assign live    = in_fill && (tag_reg != '0);

    always_comb begin
        if (live) begin
            cand_next.hit    = 1'b1;
            cand_next.tag    = tag_reg;
            cand_next.handle = handle_reg;
        end else begin
            cand_next = nb_cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            tag_reg    <= nb_tag;
            handle_reg <= nb_handle;
        end else if (cmd.write && (fill == CNT_W'(IDX))) begin
            tag_reg    <= cmd.tag;
            handle_reg <= cmd.handle;
        end else if (cmd.clear && in_fill && (tag_reg == cmd.tag)) begin
            tag_reg    <= '0;
            handle_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '0;
        end else begin
            cand_reg <= cand_next;
        end
    end

    assign tag    = tag_reg;
    assign handle = handle_reg;
    assign cand   = cand_reg;

endmodule

// File: hdl/rqdo_ctrl.sv
// ----------------------------------------------------------------------------
// rqdo_ctrl: operation sequencer
// Accepts one beat at a time, steps the cell row through pops, writes and
// clears, keeps the fill count and high-water mark, and holds the result.
// ----------------------------------------------------------------------------
module rqdo_ctrl
    import rqdo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  in_beat_t                     s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output out_beat_t                    m_data,
    input  logic [TAG_W-1:0]             head_tag,
    input  logic [HANDLE_W-1:0]          head_handle,
    input  cand_t                        head_cand,
    output cell_cmd_t                    cmd,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int CNT_W  = $clog2(DEPTH+1);
    localparam int WAIT_W = $clog2(DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_POP   = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_PEEK  = 5'b01000,
        ST_DEREF = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    peak_reg, peak_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic                pend_drop_reg, pend_drop_next;
    logic [TAG_W-1:0]    pend_tag_reg, pend_tag_next;
    logic [HANDLE_W-1:0] pend_handle_reg, pend_handle_next;
    out_beat_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;

    logic                s_accept;
    logic                out_free;
    logic                empty;
    logic                head_live;
    logic                finish;
    logic                r_ok;
    logic [TAG_W-1:0]    r_tag;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_drop;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign empty     = (fill_reg == '0);
    assign head_live = !empty && (head_tag != '0);

    always_comb begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        peak_next        = peak_reg;
        wait_next        = wait_reg;
        pend_drop_next   = pend_drop_reg;
        pend_tag_next    = pend_tag_reg;
        pend_handle_next = pend_handle_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        cmd              = '0;
        cmd.tag          = tag_reg;
        cmd.handle       = handle_reg;
        finish           = 1'b0;
        r_ok             = 1'b0;
        r_tag            = '0;
        r_handle         = '0;
        r_drop           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    wait_next        = '0;
                    pend_drop_next   = 1'b0;
                    pend_tag_next    = '0;
                    pend_handle_next = '0;
                    case (s_data.opcode)
                        OP_ADD: begin
                            state_next = (fill_reg == CNT_W'(DEPTH)) ? ST_POP : ST_ADD;
                        end
                        OP_EXTRACT: state_next = ST_POP;
                        OP_PEEK:    state_next = ST_PEEK;
                        OP_DEREF:   state_next = ST_DEREF;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end

            ST_POP: begin
                // An extract that ends this cycle must have room for its result.
                if (!((op_reg == OP_EXTRACT) && (empty || head_live) && !out_free)) begin
                    if (!empty) begin
                        cmd.shift = 1'b1;
                        fill_next = fill_reg - CNT_W'(1);
                    end
                    if (empty || head_live) begin
                        if (op_reg == OP_EXTRACT) begin
                            finish   = 1'b1;
                            r_ok     = head_live;
                            r_tag    = head_live ? head_tag : '0;
                            r_handle = head_live ? head_handle : '0;
                        end else begin
                            pend_drop_next   = head_live;
                            pend_tag_next    = head_live ? head_tag : '0;
                            pend_handle_next = head_live ? head_handle : '0;
                            state_next       = ST_ADD;
                        end
                    end
                end
            end

            ST_ADD: begin
                if (out_free) begin
                    cmd.write = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                    if (fill_next > peak_reg) begin
                        peak_next = fill_next;
                    end
                    finish   = 1'b1;
                    r_ok     = !pend_drop_reg;
                    r_tag    = pend_tag_reg;
                    r_handle = pend_handle_reg;
                    r_drop   = pend_drop_reg;
                end
            end

            ST_PEEK: begin
                // The search steps one cell per cycle and must cross the whole row to reach the head.
                if (wait_reg == WAIT_W'(DEPTH-1)) begin
                    if (out_free) begin
                        finish   = 1'b1;
                        r_ok     = head_cand.hit;
                        r_tag    = head_cand.hit ? head_cand.tag : '0;
                        r_handle = head_cand.hit ? head_cand.handle : '0;
                    end
                end else begin
                    wait_next = wait_reg + WAIT_W'(1);
                end
            end

            ST_DEREF: begin
                if (out_free) begin
                    cmd.clear = 1'b1;
                    finish    = 1'b1;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        if (finish) begin
            res_next.ok         = r_ok;
            res_next.out_tag    = r_tag;
            res_next.out_handle = r_handle;
            res_next.dropped    = r_drop;
            res_next.fill_level = LVL_W'(fill_next);
            res_next.peak_level = LVL_W'(peak_next);
            m_valid_next        = 1'b1;
            state_next          = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            peak_reg    <= peak_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg     <= s_data.opcode;
            tag_reg    <= s_data.in_tag;
            handle_reg <= s_data.in_handle;
        end
        wait_reg        <= wait_next;
        pend_drop_reg   <= pend_drop_next;
        pend_tag_reg    <= pend_tag_next;
        pend_handle_reg <= pend_handle_next;
        res_reg         <= res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;
    assign fill    = fill_reg;

endmodule

// File: hdl/ring_queue_drop_oldest_with_invalidate.sv
// Each beat runs to completion before the next is taken. An add on a full queue first pops
// entries up to the first live one, or until the queue is empty when none is live, then
// appends; an extract pops until a live entry comes out or the queue is empty; a peek
// waits for the search walking one cell per cycle to reach the head. The next beat can be
// taken at the first edge at which the result can be taken.
// Reset is synchronous and active low; entry contents are kept and never read unwritten.
// ----------------------------------------------------------------------------
// ring_queue_drop_oldest_with_invalidate: drop-oldest queue with invalidation
// A row of entry cells with the head in cell zero, driven by a sequencer that
// pops, appends, invalidates by tag and searches for the first live entry.
// ----------------------------------------------------------------------------
module ring_queue_drop_oldest_with_invalidate
    import rqdo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int CNT_W = $clog2(DEPTH+1);

    cell_cmd_t           cmd;
    logic [CNT_W-1:0]    fill;
    logic [TAG_W-1:0]    tag_w    [DEPTH+1];
    logic [HANDLE_W-1:0] handle_w [DEPTH+1];
    cand_t               cand_w   [DEPTH+1];

    // Past the tail nothing is live and a pop shifts in an empty entry.
    assign tag_w[DEPTH]    = '0;
    assign handle_w[DEPTH] = '0;
    assign cand_w[DEPTH]   = '0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            rqdo_cell #(
                .DEPTH (DEPTH),
                .IDX   (i)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .fill      (fill),
                .nb_tag    (tag_w[i+1]),
                .nb_handle (handle_w[i+1]),
                .nb_cand   (cand_w[i+1]),
                .tag       (tag_w[i]),
                .handle    (handle_w[i]),
                .cand      (cand_w[i])
            );
        end
    endgenerate

    rqdo_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .head_tag    (tag_w[0]),
        .head_handle (handle_w[0]),
        .head_cand   (cand_w[0]),
        .cmd         (cmd),
        .fill        (fill)
    );

endmodule

// File: sim/ring_queue_drop_oldest_with_invalidate_tb.sv
// ----------------------------------------------------------------------------
// ring_queue_drop_oldest_with_invalidate_tb: self-checking bench for the queue
// Drives add, extract, peek and dereference beats through the valid/ready
// input channel. Each accepted beat runs through a behavioral copy of the
// ring, and every result beat is checked against the oldest predicted result.
// Directed cases cover empty, full and all-dead queues. Random traffic then
// runs under several idle and stall patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ring_queue_drop_oldest_with_invalidate_tb;
    import rqdo_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = QDEPTH + 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    ring_queue_drop_oldest_with_invalidate #(
        .DEPTH(QDEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // Behavioral copy of the ring.
    logic [TAG_W-1:0]    ring_tag    [QDEPTH];
    logic [HANDLE_W-1:0] ring_handle [QDEPTH];
    int                  ring_head = 0;
    int                  ring_fill = 0;
    int                  ring_peak = 0;

    out_beat_t pending_results[$];
    out_beat_t want;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        stall_pct      = 0;
    int        hold_gen       = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;

    // Pop from the head until a live entry comes out or the ring runs dry.
    function automatic logic pop_first_live(output logic [TAG_W-1:0] tag,
                                            output logic [HANDLE_W-1:0] handle);
        logic [TAG_W-1:0] t;
        tag    = '0;
        handle = '0;
        while (ring_fill != 0) begin
            t         = ring_tag[ring_head];
            handle    = ring_handle[ring_head];
            ring_head = (ring_head + 1) % QDEPTH;
            ring_fill--;
            if (t != '0) begin
                tag = t;
                return 1'b1;
            end
        end
        handle = '0;
        return 1'b0;
    endfunction

    function automatic out_beat_t queue_model_step(in_beat_t b);
        out_beat_t           r;
        logic [TAG_W-1:0]    t;
        logic [HANDLE_W-1:0] h;
        int                  s;
        r = '0;
        case (b.opcode)
            OP_ADD: begin
                if (ring_fill >= QDEPTH) begin
                    r.dropped    = pop_first_live(t, h);
                    r.out_tag    = t;
                    r.out_handle = h;
                end
                if (ring_fill < QDEPTH) begin
                    s              = (ring_head + ring_fill) % QDEPTH;
                    ring_tag[s]    = b.in_tag;
                    ring_handle[s] = b.in_handle;
                    ring_fill++;
                    if (ring_fill > ring_peak) ring_peak = ring_fill;
                end
                r.ok = !r.dropped;
            end
            OP_EXTRACT: begin
                r.ok         = pop_first_live(t, h);
                r.out_tag    = t;
                r.out_handle = h;
            end
            OP_PEEK: begin
                for (int i = 0; i < ring_fill; i++) begin
                    s = (ring_head + i) % QDEPTH;
                    if (!r.ok && ring_tag[s] != '0) begin
                        r.ok         = 1'b1;
                        r.out_tag    = ring_tag[s];
                        r.out_handle = ring_handle[s];
                    end
                end
            end
            default: begin
                for (int i = 0; i < ring_fill; i++) begin
                    s = (ring_head + i) % QDEPTH;
                    if (ring_tag[s] == b.in_tag) begin
                        ring_tag[s]    = '0;
                        ring_handle[s] = '0;
                    end
                end
            end
        endcase
        r.fill_level = ring_fill[LVL_W-1:0];
        r.peak_level = ring_peak[LVL_W-1:0];
        return r;
    endfunction

    // Results are checked before the beat accepted at the same edge is predicted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat %p", m_data);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.ok !== want.ok || m_data.out_tag !== want.out_tag ||
                        m_data.out_handle !== want.out_handle ||
                        m_data.dropped !== want.dropped ||
                        m_data.fill_level !== want.fill_level ||
                        m_data.peak_level !== want.peak_level) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %p, got %p", want, m_data);
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(queue_model_step(s_data));
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    always @(posedge aclk) begin
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Leaves valid high after the beat is taken, so a back-to-back beat follows
    // without valid dropping in between.
    task automatic send_op(op_t op, logic [TAG_W-1:0] tag, logic [HANDLE_W-1:0] handle);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(8, 1) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, in_tag: tag, in_handle: handle};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [TAG_W-1:0] pick_tag();
        int r;
        r = $urandom_range(99);
        if (r < 45) return TAG_W'($urandom_range(3, 1));
        if (r < 55) return '0;
        if (r < 62) return '1;
        return TAG_W'($urandom);
    endfunction

    function automatic op_t pick_op(int add_pct);
        if ($urandom_range(99) < add_pct) return OP_ADD;
        case ($urandom_range(2))
            0:       return OP_EXTRACT;
            1:       return OP_PEEK;
            default: return OP_DEREF;
        endcase
    endfunction

    task automatic test_basic_ops();
        send_op(OP_EXTRACT, '0, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_DEREF, '0, '0);
        send_op(OP_ADD, '1, '1);
        send_op(OP_ADD, '0, '0);
        send_op(OP_ADD, 16'h0001, 16'h0000);
        send_op(OP_ADD, 16'h8000, 16'h1234);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_DEREF, '1, '0);
        send_op(OP_PEEK, '0, '0);
        // Tag zero only matches entries that are already dead.
        send_op(OP_DEREF, '0, '1);
        send_op(OP_EXTRACT, '0, '0);
        send_op(OP_EXTRACT, '0, '0);
        send_op(OP_EXTRACT, '0, '0);
        send_op(OP_ADD, 16'h5555, 16'hAAAA);
        send_op(OP_ADD, 16'hAAAA, 16'h5555);
        send_op(OP_EXTRACT, '0, '0);
        wait_results();
    endtask

    task automatic test_full_queue();
        int n;
        wait_results();
        n = ring_fill;
        repeat (n) send_op(OP_EXTRACT, '0, '0);
        wait_results();
        for (int i = 0; i < QDEPTH; i++)
            send_op(OP_ADD, (i < 5) ? 16'h0007 : 16'h0009, HANDLE_W'(i));
        // Dead entries at the head are skipped before the first live one is dropped.
        send_op(OP_DEREF, 16'h0007, '0);
        send_op(OP_ADD, 16'h0123, 16'hABCD);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_DEREF, 16'h0009, '0);
        send_op(OP_DEREF, 16'h0123, '0);
        repeat (5) send_op(OP_ADD, '0, HANDLE_W'($urandom));
        // Full of dead entries only: the add empties the ring and drops nothing.
        send_op(OP_ADD, '1, 16'h0001);
        send_op(OP_DEREF, '1, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_EXTRACT, '0, '0);
        wait_results();
    endtask

    task automatic test_backpressure();
        hold_gen++;
        repeat (80) send_op(($urandom_range(9) == 0) ? OP_DEREF : OP_ADD, pick_tag(),
                            HANDLE_W'($urandom));
        wait_results();
    endtask

    task automatic test_random_mix();
        int idle_set  [4] = '{0, 70, 0, 9};
        int stall_set [4] = '{0, 0, 70, 9};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_set[p];
            stall_pct     = stall_set[p];
            for (int k = 0; k < 60; k++)
                send_op(pick_op(((k / 25) % 2 == 0) ? 75 : 30), pick_tag(),
                        HANDLE_W'($urandom));
            wait_results();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_ops();
        test_full_queue();
        test_backpressure();
        test_random_mix();
        wait_results();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/rqdo_pkg.sv
hdl/rqdo_cell.sv
hdl/rqdo_ctrl.sv
hdl/ring_queue_drop_oldest_with_invalidate.sv
sim/ring_queue_drop_oldest_with_invalidate_tb.sv
